[design/jsu_pkg.sv]
// ---------------------------------------------------------------------------
// JSON string unescape package
// Shared result type, status codes and hex digit decode for the unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

  // Status codes carried on the final item of a string
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISS_QUOTE = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
  localparam logic [2:0] ST_BAD_HEX    = 3'd3;
  localparam logic [2:0] ST_BAD_SURR   = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Most result items one input item can produce
  localparam int MAX_RES = 4;

  // One result item
  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status_code;
  } res_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[design/json_string_unescape_utf8_core.sv]
// ---------------------------------------------------------------------------
// JSON string unescaper with UTF-8 output
// Decodes JSON string escapes, joins surrogate pairs and emits UTF-8 bytes.
// ---------------------------------------------------------------------------
// Feed JSON text one byte per item on text_*; decoded bytes and one final
// status per string leave on res_*. Bytes outside a string are dropped until
// an opening quote. Every input item is decoded in the cycle it is accepted
// and its 0 to 4 result items are loaded into a four-slot output buffer that
// drains one item per cycle while res_ready is high. A new byte is taken
// when that buffer is empty or its only item leaves in the same cycle, so
// plain text and single-byte escapes run at one byte per cycle; a multi-byte
// \uXXXX holds the input until its last byte leaves. On an error status the
// consumer should discard the data bytes already delivered for that string.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8_core
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_ready,
  input  logic [7:0] text_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       is_status,
  output logic [7:0] data_byte,
  output logic [2:0] status_code,
  output logic       last
);

  // Phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_STR  = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX1 = 3'd3;
  localparam logic [2:0] PH_SBS  = 3'd4;
  localparam logic [2:0] PH_SU   = 3'd5;
  localparam logic [2:0] PH_HEX2 = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [15:0] code_unit, code_unit_next;
  logic [9:0]  high_bits, high_bits_next;
  logic [1:0]  hex_count, hex_count_next;

  res_t        slot [MAX_RES];
  logic [2:0]  buf_cnt;

  res_t        new_res [MAX_RES];
  logic [2:0]  new_cnt;

  logic        acc, pop;
  logic [4:0]  hx;
  logic [15:0] cu_shift;
  logic [20:0] cp;
  logic        emit;

  assign res_valid  = (buf_cnt != 3'd0);
  assign pop        = res_valid && res_ready;
  assign text_ready = (buf_cnt == 3'd0) || (buf_cnt == 3'd1 && res_ready);
  assign acc        = text_valid && text_ready;

  assign is_status   = slot[0].is_status;
  assign data_byte   = slot[0].data_byte;
  assign status_code = slot[0].status_code;
  assign last        = slot[0].is_status;

  assign hx       = hex_decode(text_byte);
  assign cu_shift = {code_unit[11:0], hx[3:0]};

  // Decode one text byte against the current phase
  always_comb begin
    phase_next     = phase;
    code_unit_next = code_unit;
    high_bits_next = high_bits;
    hex_count_next = hex_count;
    new_cnt        = 3'd0;
    emit           = 1'b0;
    cp             = 21'd0;
    for (int i = 0; i < MAX_RES; i++) new_res[i] = '0;

    unique case (phase)
      PH_STR: begin
        if (text_byte == CH_QUOTE) begin
          new_res[0] = '{1'b1, 8'h00, ST_OK};
          new_cnt    = 3'd1;
        end else if (text_byte == CH_BSL) begin
          phase_next = PH_ESC;
        end else if (text_byte == 8'h00) begin
          new_res[0] = '{1'b1, 8'h00, ST_MISS_QUOTE};
          new_cnt    = 3'd1;
        end else if (text_byte < CH_SPACE) begin
          new_res[0] = '{1'b1, 8'h00, ST_BAD_CHAR};
          new_cnt    = 3'd1;
        end else begin
          new_res[0] = '{1'b0, text_byte, ST_OK};
          new_cnt    = 3'd1;
        end
      end
      PH_ESC: begin
        phase_next = PH_STR;
        new_cnt    = 3'd1;
        unique case (text_byte)
          CH_QUOTE, CH_BSL, CH_SLASH: new_res[0] = '{1'b0, text_byte, ST_OK};
          CH_B: new_res[0] = '{1'b0, 8'h08, ST_OK};
          CH_T: new_res[0] = '{1'b0, 8'h09, ST_OK};
          CH_N: new_res[0] = '{1'b0, 8'h0A, ST_OK};
          CH_R: new_res[0] = '{1'b0, 8'h0D, ST_OK};
          CH_F: new_res[0] = '{1'b0, 8'h0C, ST_OK};
          CH_U: begin
            phase_next     = PH_HEX1;
            code_unit_next = 16'd0;
            hex_count_next = 2'd0;
            new_cnt        = 3'd0;
          end
          default: new_res[0] = '{1'b1, 8'h00, ST_BAD_CHAR};
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        if (!hx[4]) begin
          new_res[0] = '{1'b1, 8'h00, ST_BAD_HEX};
          new_cnt    = 3'd1;
        end else if (hex_count != 2'd3) begin
          code_unit_next = cu_shift;
          hex_count_next = hex_count + 2'd1;
        end else begin
          code_unit_next = 16'd0;
          hex_count_next = 2'd0;
          if (phase == PH_HEX1) begin
            if (cu_shift[15:10] == 6'b110110) begin
              // High surrogate: hold its bits and wait for the low half
              high_bits_next = cu_shift[9:0];
              phase_next     = PH_SBS;
            end else begin
              phase_next = PH_STR;
              emit       = 1'b1;
              cp         = {5'd0, cu_shift};
            end
          end else if (cu_shift[15:10] != 6'b110111) begin
            new_res[0] = '{1'b1, 8'h00, ST_BAD_SURR};
            new_cnt    = 3'd1;
          end else begin
            phase_next = PH_STR;
            emit       = 1'b1;
            cp         = {1'b0, high_bits, cu_shift[9:0]} + 21'h10000;
          end
        end
      end
      PH_SBS: begin
        if (text_byte != CH_BSL) begin
          new_res[0] = '{1'b1, 8'h00, ST_BAD_SURR};
          new_cnt    = 3'd1;
        end else begin
          phase_next = PH_SU;
        end
      end
      PH_SU: begin
        if (text_byte != CH_U) begin
          new_res[0] = '{1'b1, 8'h00, ST_BAD_SURR};
          new_cnt    = 3'd1;
        end else begin
          phase_next     = PH_HEX2;
          code_unit_next = 16'd0;
          hex_count_next = 2'd0;
        end
      end
      default: begin
        phase_next = (text_byte == CH_QUOTE) ? PH_STR : PH_IDLE;
      end
    endcase

    // Encode a finished code point as UTF-8
    if (emit) begin
      if (cp <= 21'h7F) begin
        new_res[0] = '{1'b0, cp[7:0], ST_OK};
        new_cnt    = 3'd1;
      end else if (cp <= 21'h7FF) begin
        new_res[0] = '{1'b0, {3'b110, cp[10:6]}, ST_OK};
        new_res[1] = '{1'b0, {2'b10, cp[5:0]}, ST_OK};
        new_cnt    = 3'd2;
      end else if (cp <= 21'hFFFF) begin
        new_res[0] = '{1'b0, {4'b1110, cp[15:12]}, ST_OK};
        new_res[1] = '{1'b0, {2'b10, cp[11:6]}, ST_OK};
        new_res[2] = '{1'b0, {2'b10, cp[5:0]}, ST_OK};
        new_cnt    = 3'd3;
      end else begin
        new_res[0] = '{1'b0, {5'b11110, cp[20:18]}, ST_OK};
        new_res[1] = '{1'b0, {2'b10, cp[17:12]}, ST_OK};
        new_res[2] = '{1'b0, {2'b10, cp[11:6]}, ST_OK};
        new_res[3] = '{1'b0, {2'b10, cp[5:0]}, ST_OK};
        new_cnt    = 3'd4;
      end
    end

    // Any status ends the string
    if (new_res[0].is_status) begin
      phase_next     = PH_IDLE;
      code_unit_next = 16'd0;
      hex_count_next = 2'd0;
    end
  end

  // Advance decoder state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      code_unit <= 16'd0;
      high_bits <= 10'd0;
      hex_count <= 2'd0;
    end else if (acc) begin
      phase     <= phase_next;
      code_unit <= code_unit_next;
      high_bits <= high_bits_next;
      hex_count <= hex_count_next;
    end
  end

  // Output buffer: load on accept, otherwise shift on each delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 3'd0;
    end else if (acc) begin
      buf_cnt <= new_cnt;
    end else if (pop) begin
      buf_cnt <= buf_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < MAX_RES; i++) slot[i] <= new_res[i];
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) slot[i] <= slot[i + 1];
      slot[MAX_RES - 1] <= '0;
    end
  end

  // Buffer count never exceeds four, the most results one item can produce
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    buf_cnt <= 3'd4)
    else $error("output buffer count out of range");

  // A status item is always the only one left in the buffer
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    (res_valid && is_status) |-> (buf_cnt == 3'd1))
    else $error("status item not alone in buffer");

  // A status result returns the decoder to idle
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    (acc && new_cnt != 3'd0 && new_res[0].is_status) |=> (phase == PH_IDLE))
    else $error("decoder not idle after status");

  // Hex digit count runs only inside a hex quad
  a_hex_phase: assert property (@(posedge clk) disable iff (rst)
    (hex_count != 2'd0) |-> (phase == PH_HEX1 || phase == PH_HEX2))
    else $error("hex count outside hex quad");

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// JSON string unescaper testbench
// Drives JSON text bytes through the valid/ready input channel, predicts the
// decoded UTF-8 bytes and final status of each string, and checks every
// result item leaving the core in order. A short directed list comes first,
// then randomly built strings with random content, broken escapes, broken
// surrogate pairs and idle-state noise, under random idling on both sides.
// ---------------------------------------------------------------------------
module testbench
  import jsu_pkg::*;
();

  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;
  localparam int LIMIT_CYCLES = 300000;

  // Scanner position within the text
  typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_TEXT,
    SCAN_ESCAPE,
    SCAN_QUAD_HI,
    SCAN_PAIR_BSL,
    SCAN_PAIR_U,
    SCAN_QUAD_LO
  } scan_e;

  // How the expectation of a directed row is formed
  typedef enum logic [1:0] {
    WANT_MODEL,
    WANT_NONE,
    WANT_DATA,
    WANT_STATUS
  } want_e;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] b;
    want_e      kind;
    logic [7:0] val;
  } dir_row_t;

  localparam logic [7:0] ESC_LETTERS [8] = '{
    CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_T, CH_N, CH_R, CH_F
  };
  localparam logic [15:0] EDGE_UNITS [6] = '{
    16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF
  };

  logic       clk;
  logic       rst;
  logic       text_valid;
  logic       text_ready;
  logic [7:0] text_byte;
  logic       res_valid;
  logic       res_ready;
  logic       is_status;
  logic [7:0] data_byte;
  logic [2:0] status_code;
  logic       last;

  // Expectation attached to the byte on offer
  want_e      row_kind;
  logic [7:0] row_val;

  // Predictor state
  scan_e       scan;
  logic [15:0] quad;
  logic [9:0]  hi_bits;
  logic [1:0]  ndig;
  out_item_t   decoded [MAX_RES];

  out_item_t pending_out_q [$];
  int        string_items = 0;
  int        fails = 0;
  bit        calm = 1'b0;
  bit        tx_gappy = 1'b1;
  bit        rx_gappy = 1'b1;
  bit        held = 1'b0;

  // Directed text: idle noise, plain bytes at the extremes, an escape,
  // the largest surrogate pair, and the error endings
  dir_row_t dir_rows [31] = '{
    '{8'h00, WANT_NONE, 8'h00},
    '{8'h7E, WANT_NONE, 8'h00},
    '{CH_QUOTE, WANT_NONE, 8'h00},
    '{8'h20, WANT_DATA, 8'h20},
    '{8'hFF, WANT_DATA, 8'hFF},
    '{CH_BSL, WANT_NONE, 8'h00},
    '{CH_N, WANT_DATA, 8'h0A},
    '{CH_BSL, WANT_NONE, 8'h00},
    '{CH_U, WANT_NONE, 8'h00},
    '{8'h44, WANT_NONE, 8'h00},
    '{8'h42, WANT_NONE, 8'h00},
    '{8'h66, WANT_NONE, 8'h00},
    '{8'h46, WANT_NONE, 8'h00},
    '{CH_BSL, WANT_NONE, 8'h00},
    '{CH_U, WANT_NONE, 8'h00},
    '{8'h64, WANT_NONE, 8'h00},
    '{8'h46, WANT_NONE, 8'h00},
    '{8'h66, WANT_NONE, 8'h00},
    '{8'h66, WANT_MODEL, 8'h00},
    '{CH_QUOTE, WANT_STATUS, 8'(ST_OK)},
    '{CH_QUOTE, WANT_NONE, 8'h00},
    '{8'h00, WANT_STATUS, 8'(ST_MISS_QUOTE)},
    '{CH_QUOTE, WANT_NONE, 8'h00},
    '{8'h1F, WANT_STATUS, 8'(ST_BAD_CHAR)},
    '{CH_QUOTE, WANT_NONE, 8'h00},
    '{CH_BSL, WANT_NONE, 8'h00},
    '{8'h00, WANT_STATUS, 8'(ST_BAD_CHAR)},
    '{CH_QUOTE, WANT_NONE, 8'h00},
    '{CH_BSL, WANT_NONE, 8'h00},
    '{CH_U, WANT_NONE, 8'h00},
    '{8'h00, WANT_STATUS, 8'(ST_BAD_HEX)}
  };

  json_string_unescape_utf8_core dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_byte   (text_byte),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .is_status   (is_status),
    .data_byte   (data_byte),
    .status_code (status_code),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic out_item_t data_item(input logic [7:0] b);
    return '{is_status: 1'b0, data_byte: b, status_code: ST_OK, last: 1'b0};
  endfunction

  // End the string with a status and fall back to idle
  function automatic int close_string(input logic [2:0] code);
    decoded[0] = '{is_status: 1'b1, data_byte: 8'h00, status_code: code, last: 1'b1};
    scan = SCAN_IDLE;
    quad = '0;
    ndig = '0;
    return 1;
  endfunction

  function automatic int put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      decoded[0] = data_item(cp[7:0]);
      return 1;
    end
    if (cp <= 21'h7FF) begin
      decoded[0] = data_item({3'b110, cp[10:6]});
      decoded[1] = data_item({2'b10, cp[5:0]});
      return 2;
    end
    if (cp <= 21'hFFFF) begin
      decoded[0] = data_item({4'b1110, cp[15:12]});
      decoded[1] = data_item({2'b10, cp[11:6]});
      decoded[2] = data_item({2'b10, cp[5:0]});
      return 3;
    end
    decoded[0] = data_item({5'b11110, cp[20:18]});
    decoded[1] = data_item({2'b10, cp[17:12]});
    decoded[2] = data_item({2'b10, cp[11:6]});
    decoded[3] = data_item({2'b10, cp[5:0]});
    return 4;
  endfunction

  // Advance the scanner by one text byte; fill decoded[] and return its count
  function automatic int unescape_byte(input logic [7:0] c);
    int          n;
    int          h;
    logic [15:0] u;
    n = 0;
    case (scan)
      SCAN_TEXT: begin
        if (c == CH_QUOTE) n = close_string(ST_OK);
        else if (c == CH_BSL) scan = SCAN_ESCAPE;
        else if (c == 8'h00) n = close_string(ST_MISS_QUOTE);
        else if (c < CH_SPACE) n = close_string(ST_BAD_CHAR);
        else begin
          decoded[0] = data_item(c);
          n = 1;
        end
      end
      SCAN_ESCAPE: begin
        scan = SCAN_TEXT;
        n = 1;
        case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: decoded[0] = data_item(c);
          CH_B: decoded[0] = data_item(8'h08);
          CH_T: decoded[0] = data_item(8'h09);
          CH_N: decoded[0] = data_item(8'h0A);
          CH_R: decoded[0] = data_item(8'h0D);
          CH_F: decoded[0] = data_item(8'h0C);
          CH_U: begin
            scan = SCAN_QUAD_HI;
            quad = '0;
            ndig = '0;
            n = 0;
          end
          default: n = close_string(ST_BAD_CHAR);
        endcase
      end
      SCAN_QUAD_HI, SCAN_QUAD_LO: begin
        if (c inside {[8'h30:8'h39]}) h = int'(c - 8'h30);
        else if (c inside {[8'h41:8'h46]}) h = int'(c - 8'h37);
        else if (c inside {[8'h61:8'h66]}) h = int'(c - 8'h57);
        else h = -1;
        if (h < 0) n = close_string(ST_BAD_HEX);
        else begin
          quad = {quad[11:0], 4'(h)};
          if (ndig != 2'd3) ndig = ndig + 2'd1;
          else begin
            ndig = '0;
            u = quad;
            quad = '0;
            if (scan == SCAN_QUAD_HI) begin
              if (u inside {[16'hD800:16'hDBFF]}) begin
                // Hold the high half until the low surrogate arrives
                hi_bits = u[9:0];
                scan = SCAN_PAIR_BSL;
              end else begin
                scan = SCAN_TEXT;
                n = put_utf8({5'd0, u});
              end
            end else if (!(u inside {[16'hDC00:16'hDFFF]})) begin
              n = close_string(ST_BAD_SURR);
            end else begin
              scan = SCAN_TEXT;
              n = put_utf8({1'b0, hi_bits, u[9:0]} + 21'h10000);
            end
          end
        end
      end
      SCAN_PAIR_BSL: begin
        if (c != CH_BSL) n = close_string(ST_BAD_SURR);
        else scan = SCAN_PAIR_U;
      end
      SCAN_PAIR_U: begin
        if (c != CH_U) n = close_string(ST_BAD_SURR);
        else begin
          scan = SCAN_QUAD_LO;
          quad = '0;
          ndig = '0;
        end
      end
      default: begin
        if (c == CH_QUOTE) scan = SCAN_TEXT;
        else scan = SCAN_IDLE;
      end
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Predict on every accepted text item, check every accepted result item
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    int        n;
    if (rst) begin
      scan = SCAN_IDLE;
      quad = '0;
      hi_bits = '0;
      ndig = '0;
    end else begin
      if (text_valid && text_ready) begin
        if (scan != SCAN_IDLE || text_byte == CH_QUOTE) string_items++;
        n = unescape_byte(text_byte);
        case (row_kind)
          WANT_MODEL: for (int i = 0; i < n; i++) pending_out_q = {pending_out_q, decoded[i]};
          WANT_DATA: pending_out_q = {pending_out_q, data_item(row_val)};
          WANT_STATUS:
            pending_out_q = {pending_out_q, out_item_t'({1'b1, 8'h00, row_val[2:0], 1'b1})};
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        got = {is_status, data_byte, status_code, last};
        if (pending_out_q.size() == 0) begin
          $display("%0t: unexpected result: is_status=%0b data=%02h code=%0d last=%0b",
                   $time, got.is_status, got.data_byte, got.status_code, got.last);
          fails++;
        end else begin
          want = pending_out_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected is_status=%0b data=%02h code=%0d last=%0b",
                     $time, want.is_status, want.data_byte, want.status_code, want.last);
            $display("%0t:           actual   is_status=%0b data=%02h code=%0d last=%0b",
                     $time, got.is_status, got.data_byte, got.status_code, got.last);
            fails++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Text sender
  // ---------------------------------------------------------------------

  // Offer one item, hold it until taken, then maybe idle for a burst
  task automatic offer_byte(input logic [7:0] b, input want_e kind, input logic [7:0] val);
    text_valid <= 1'b1;
    text_byte  <= b;
    row_kind   <= kind;
    row_val    <= val;
    do @(posedge clk); while (!(text_valid && text_ready));
    if (!calm && tx_gappy && $urandom_range(0, 4) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic put(input logic [7:0] b);
    offer_byte(b, WANT_MODEL, 8'h00);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  // Send \u and four hex digits in mixed case
  task automatic put_unit(input logic [15:0] v);
    put(CH_BSL);
    put(CH_U);
    for (int i = 3; i >= 0; i--) put(hex_char(v[i*4 +: 4]));
  endtask

  task automatic put_piece();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSL);
        put(b);
      end
      4, 5: begin
        put(CH_BSL);
        put(ESC_LETTERS[$urandom_range(0, 7)]);
      end
      6, 7: begin
        case ($urandom_range(0, 4))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          2: v = 16'($urandom_range(16'h800, 16'hD7FF));
          3: v = 16'($urandom_range(16'hE000, 16'hFFFF));
          default: v = EDGE_UNITS[$urandom_range(0, 5)];
        endcase
        put_unit(v);
      end
      8: begin
        put_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        put_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
      // lone low surrogate
      default: put_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
    endcase
  endtask

  // Close the string, mostly cleanly, otherwise with one kind of error
  task automatic put_ending();
    logic [7:0]  b;
    logic [15:0] v;
    int          n;
    case ($urandom_range(0, 13))
      7: put(8'h00);
      8: put(8'($urandom_range(1, 31)));
      9: begin
        put(CH_BSL);
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_T, CH_N, CH_R, CH_F, CH_U});
        put(b);
      end
      10, 11: begin
        if ($urandom_range(0, 1) != 0) put_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        put(CH_BSL);
        put(CH_U);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) put(hex_char(4'($urandom_range(0, 15))));
        do b = 8'($urandom_range(0, 255));
        while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
        put(b);
      end
      12: begin
        put_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        case ($urandom_range(0, 2))
          0: begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_BSL);
            put(b);
          end
          1: begin
            put(CH_BSL);
            do b = 8'($urandom_range(0, 255)); while (b == CH_U);
            put(b);
          end
          default: begin
            do v = 16'($urandom); while (v inside {[16'hDC00:16'hDFFF]});
            put_unit(v);
          end
        endcase
      end
      default: put(CH_QUOTE);
    endcase
  endtask

  initial begin
    logic [7:0] b;
    int         pieces;
    int         waited;
    rst        <= 1'b1;
    text_valid <= 1'b0;
    text_byte  <= 8'h00;
    row_kind   <= WANT_MODEL;
    row_val    <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    foreach (dir_rows[k]) offer_byte(dir_rows[k].b, dir_rows[k].kind, dir_rows[k].val);

    // Random strings, with noise between them while idle
    while (string_items < RANDOM_ITEMS) begin
      calm = (string_items >= RANDOM_ITEMS - CALM_ITEMS);
      tx_gappy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          put(b);
        end
      end
      put(CH_QUOTE);
      pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      repeat (pieces) put_piece();
      put_ending();
    end
    calm = 1'b1;
    text_valid <= 1'b0;

    // Drain, then give the core time to show anything extra
    waited = 0;
    @(negedge clk);
    while (pending_out_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_out_q.size() != 0) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_out_q.size());
      $display("json_string_unescape_utf8_core test failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      @(negedge clk);
      if (pending_out_q.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, pending_out_q.size());
        fails++;
      end
      if (fails == 0)
        $display("json_string_unescape_utf8_core test passed");
      else
        $display("json_string_unescape_utf8_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver: random stalls, one long hold-off to fill the core
  // ---------------------------------------------------------------------
  initial begin
    res_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!held && string_items >= 150) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && rx_gappy && $urandom_range(0, 3) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        if ($urandom_range(0, 7) == 0) rx_gappy = !rx_gappy;
      end
    end
  end

  // Stop a hung run
  initial begin
    #(LIMIT_CYCLES * 8);
    $display("%0t: run limit reached", $time);
    $display("json_string_unescape_utf8_core test failed");
    $finish;
  end

endmodule

[json_string_unescape_utf8_core.f]
design/jsu_pkg.sv
design/json_string_unescape_utf8_core.sv
verif/testbench.sv
